// ===== design/wfr_pkg.sv =====
// Shared types, constants and the helper function of the serial frame receiver.
package wfr_pkg;

   localparam int BYTE_W              = 8;
   localparam int KIND_W              = 3;
   localparam int POS_W               = 10;
   localparam int LEN_W               = 11;
   localparam int HDR_LEN_W           = 16;
   localparam int ADDR_W              = 3;
   localparam int APB_DATA_W          = 32;
   localparam int MAX_PAYLOAD_DEFAULT = 1024;

   localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hFC;

   // Register index within the configuration map.
   localparam logic REG_HEAD = 1'b0;
   localparam logic REG_TAIL = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      EV_DATA    = 3'd0,
      EV_GOOD    = 3'd1,
      EV_BAD     = 3'd2,
      EV_OVER    = 3'd3,
      EV_RESTART = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] head_byte;
      logic [BYTE_W-1:0] tail_byte;
   } cfg_type;

   typedef struct packed {
      logic                  has_result;
      event_kind_type        event_kind;
      logic [BYTE_W-1:0]     data_byte;
      logic [POS_W-1:0]      payload_position;
      logic [BYTE_W-1:0]     frame_type;
      logic [LEN_W-1:0]      frame_length;
   } rsp_item_type;

   // Header length saturated to the width of the reported length.
   function automatic logic [LEN_W-1:0] sat_len(input logic [HDR_LEN_W-1:0] len);
      logic [HDR_LEN_W-1:0] limit;
      limit = HDR_LEN_W'({LEN_W{1'b1}});
      return (len > limit) ? {LEN_W{1'b1}} : len[LEN_W-1:0];
   endfunction

endpackage

// ===== design/wfr_if.sv =====
// Valid/ready channel interfaces for received bytes and frame events.
interface wfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [wfr_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
   modport mon    (input valid, input rx_byte, input ready);
endinterface

interface wfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wfr_pkg::KIND_W-1:0]   event_kind;
   logic [wfr_pkg::BYTE_W-1:0]   data_byte;
   logic [wfr_pkg::POS_W-1:0]    payload_position;
   logic [wfr_pkg::BYTE_W-1:0]   frame_type;
   logic [wfr_pkg::LEN_W-1:0]    frame_length;

   modport source (output valid, output event_kind, output data_byte,
                   output payload_position, output frame_type, output frame_length,
                   input ready);
   modport sink   (input valid, input event_kind, input data_byte,
                   input payload_position, input frame_type, input frame_length,
                   output ready);
   modport mon    (input valid, input event_kind, input data_byte,
                   input payload_position, input frame_type, input frame_length,
                   input ready);
endinterface

// ===== design/wfr_csr.sv =====
// APB register block holding the head and tail byte values.
module wfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wfr_pkg::ADDR_W-1:0]        paddr,
   input  logic [wfr_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [wfr_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready,
   output wfr_pkg::cfg_type                  cfg
);
   import wfr_pkg::*;

   logic [BYTE_W-1:0] head_ff, head_in;
   logic [BYTE_W-1:0] tail_ff, tail_in;
   logic              wr_en;
   logic              reg_sel;

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_HEAD: head_in = pwdata[BYTE_W-1:0];
            REG_TAIL: tail_in = pwdata[BYTE_W-1:0];
            default:  head_in = head_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         tail_ff <= TAIL_RESET;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign prdata = APB_DATA_W'((reg_sel == REG_TAIL) ? tail_ff : head_ff);
   assign pready = 1'b1;

   assign cfg.head_byte = head_ff;
   assign cfg.tail_byte = tail_ff;

endmodule

// ===== design/wfr_deframer.sv =====
// Frame state and per-byte decode: turns one byte into at most one event.
module wfr_deframer #(
   parameter int MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wfr_pkg::cfg_type             cfg,
   input  logic                         step,
   input  logic [wfr_pkg::BYTE_W-1:0]   rx_byte,
   output wfr_pkg::rsp_item_type        result
);
   import wfr_pkg::*;

   localparam int IW = $clog2(MAX_PAYLOAD + 1);

   logic                  in_frame_ff, in_frame_in;
   logic [IW-1:0]         index_ff, index_in;
   logic [IW-1:0]         declared_ff, declared_in;
   logic [BYTE_W-1:0]     len_low_ff, len_low_in;
   logic [BYTE_W-1:0]     type_ff, type_in;

   logic                  is_head;
   logic                  at_len_hi;
   logic [HDR_LEN_W-1:0]  hdr_len;
   logic                  over;
   logic [IW-1:0]         decl_now;
   logic                  tail_hit;
   logic                  cut;

   assign is_head   = (rx_byte == cfg.head_byte);
   assign at_len_hi = (index_ff == IW'(3));
   assign hdr_len   = {rx_byte, len_low_ff};
   assign over      = ({1'b0, hdr_len} > (HDR_LEN_W+1)'(MAX_PAYLOAD));
   assign decl_now  = at_len_hi ? hdr_len[IW-1:0] : declared_ff;
   assign tail_hit  = ({1'b0, index_ff} >= ({1'b0, decl_now} + (IW+1)'(4)));
   assign cut       = (index_ff >= IW'(MAX_PAYLOAD));

   always_comb begin
      in_frame_in = in_frame_ff;
      index_in    = index_ff;
      declared_in = declared_ff;
      len_low_in  = len_low_ff;
      type_in     = type_ff;

      result                  = '0;
      result.event_kind       = EV_DATA;
      result.frame_type       = type_ff;
      result.frame_length     = sat_len(HDR_LEN_W'(decl_now));

      priority if (is_head) begin
         // A head byte always opens a fresh frame; mid-frame it reports a restart.
         result.has_result   = in_frame_ff;
         result.event_kind   = EV_RESTART;
         result.frame_length = '0;
         in_frame_in         = 1'b1;
         index_in            = IW'(1);
         declared_in         = IW'(MAX_PAYLOAD);
         len_low_in          = '0;
         type_in             = '0;
      end else if (!in_frame_ff) begin
         result.has_result = 1'b0;
      end else if (at_len_hi && over) begin
         result.has_result   = 1'b1;
         result.event_kind   = EV_OVER;
         result.frame_length = sat_len(hdr_len);
         in_frame_in         = 1'b0;
         index_in            = '0;
      end else if (tail_hit) begin
         result.has_result = 1'b1;
         result.event_kind = (rx_byte == cfg.tail_byte) ? EV_GOOD : EV_BAD;
         in_frame_in       = 1'b0;
         index_in          = '0;
         declared_in       = decl_now;
      end else if (cut) begin
         result.has_result = 1'b1;
         result.event_kind = EV_BAD;
         in_frame_in       = 1'b0;
         index_in          = '0;
         declared_in       = decl_now;
      end else begin
         index_in    = index_ff + IW'(1);
         declared_in = decl_now;
         if (index_ff == IW'(1)) begin
            type_in = rx_byte;
         end
         if (index_ff == IW'(2)) begin
            len_low_in = rx_byte;
         end
         if (index_ff >= IW'(4)) begin
            result.has_result       = 1'b1;
            result.data_byte        = rx_byte;
            result.payload_position = POS_W'(index_ff - IW'(4));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         index_ff    <= '0;
         declared_ff <= IW'(MAX_PAYLOAD);
         len_low_ff  <= '0;
         type_ff     <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         index_ff    <= index_in;
         declared_ff <= declared_in;
         len_low_ff  <= len_low_in;
         type_ff     <= type_in;
      end
   end

endmodule

// ===== design/wifi_frame_receiver_top.sv =====
// Top level of the serial frame receiver: byte channel in, frame events out.
//
// The req_ch channel carries one received byte per item. The rsp_ch channel
// carries event items: a payload byte with its offset, or a frame outcome
// (good, bad tail or cut off, length over limit, restarted by a head byte).
// Bytes that cause no event, such as header bytes or bytes outside a frame,
// are consumed silently. The APB port sets the head and tail byte values and
// should only be written while no bytes are in flight.
//
// A byte accepted into the input register is decoded once the result register
// is free or is being emptied, and its event item is then registered in the
// result register and presented on rsp_ch until it is accepted.
// One byte is taken in every cycle as long as the result register is free or
// is being emptied in the same cycle; the decode of one byte against the
// frame state is the single stage that sets this rate.
//
// Reset clears the frame state, empties both registers and restores the
// head byte to 0xA5 and the tail byte to 0xFC. When the event receiver
// stalls, the pending event is held, one more byte waits in the input
// register, and req_ch.ready drops until the event is taken.
module wifi_frame_receiver_top #(
   parameter int MAX_PAYLOAD = wfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   wfr_req_if.sink                           req_ch,
   wfr_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wfr_pkg::ADDR_W-1:0]        paddr,
   input  logic [wfr_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [wfr_pkg::APB_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import wfr_pkg::*;

   cfg_type           cfg;
   rsp_item_type      result;

   // Input register: one byte waiting to be decoded.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Result register: one event item waiting to be taken.
   logic              out_valid_ff, out_valid_in;
   rsp_item_type      out_item_ff;

   logic              step;

   // Decode the held byte whenever its event, if any, has somewhere to go.
   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   assign in_valid_in  = req_ch.valid || (in_valid_ff && !step);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (step) begin
         out_valid_in = result.has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      if (step && result.has_result) begin
         out_item_ff <= result;
      end
   end

   wfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wfr_deframer #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.event_kind       = out_item_ff.event_kind;
   assign rsp_ch.data_byte        = out_item_ff.data_byte;
   assign rsp_ch.payload_position = out_item_ff.payload_position;
   assign rsp_ch.frame_type       = out_item_ff.frame_type;
   assign rsp_ch.frame_length     = out_item_ff.frame_length;

endmodule

// ===== design/wfr_checker.sv =====
// Port-level checks on the frame receiver, bound to the top level.
module wfr_checker (
   input logic       clock,
   input logic       reset,
   wfr_req_if.sink   req_ch,
   wfr_rsp_if.source rsp_ch
);
   import wfr_pkg::*;

   // A pending event item is not withdrawn while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("event item dropped while stalled");

   // Only payload items carry a data byte and an offset.
   a_non_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.event_kind != EV_DATA)
      |-> (rsp_ch.data_byte == '0) && (rsp_ch.payload_position == '0))
      else $error("non-payload event carries payload fields");

   // A restart reports no length.
   a_restart_len: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.event_kind == EV_RESTART) |-> (rsp_ch.frame_length == '0))
      else $error("restart event carries a length");

   // Event kinds stay within the defined codes.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.event_kind == EV_DATA) || (rsp_ch.event_kind == EV_GOOD)
         || (rsp_ch.event_kind == EV_BAD) || (rsp_ch.event_kind == EV_OVER)
         || (rsp_ch.event_kind == EV_RESTART))
      else $error("undefined event kind");

   // The cycle after a reset edge shows no event and an open input.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && req_ch.ready)
      else $error("event present or input blocked right after reset");

endmodule

bind wifi_frame_receiver_top wfr_checker u_wfr_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
